@@ hw/rtl/srecord_s2_to_binary_top_assert.svh @@
// assertion macros for the s2 decoder
`ifndef SRECORD_S2_TO_BINARY_TOP_ASSERT_SVH
`define SRECORD_S2_TO_BINARY_TOP_ASSERT_SVH

// property checked on every rising edge outside reset
`define SR2B_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every rising edge, reset included
`define SR2B_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hw/rtl/sr2b_pkg.sv @@
package sr2b_pkg;

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_TYPE  = 3'd1;
   localparam logic [2:0] PH_COUNT = 3'd2;
   localparam logic [2:0] PH_ADDR  = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_CSUM  = 3'd5;

   localparam logic [1:0] K_DATA   = 2'd0;
   localparam logic [1:0] K_ACCEPT = 2'd1;
   localparam logic [1:0] K_ERROR  = 2'd2;
   localparam logic [1:0] K_END    = 2'd3;

   localparam logic [2:0] E_NONE      = 3'd0;
   localparam logic [2:0] E_TYPE      = 3'd1;
   localparam logic [2:0] E_SHORT     = 3'd2;
   localparam logic [2:0] E_GAP       = 3'd3;
   localparam logic [2:0] E_NONHEX    = 3'd4;
   localparam logic [2:0] E_CHECKSUM  = 3'd5;
   localparam logic [2:0] E_TRUNCATED = 3'd6;

   localparam logic [7:0] CH_S   = 8'h53;
   localparam logic [7:0] CH_TWO = 8'h32;

   localparam int OFFSET_W = 24;

   typedef struct packed {
      logic                valid;
      logic [1:0]          kind;
      logic [7:0]          data;
      logic [OFFSET_W-1:0] offset;
      logic [2:0]          err;
   } res_type;

   // bit 4 set when the character is a hex digit, low bits hold its value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/srecord_s2_to_binary_top.sv @@
// an accepted item is held in the input register, and any result it gives is registered for rsp
// throughput: one character item per cycle while rsp is not stalled, limited by the single parse state update
// the input register and the result register each free up as they are passed on
// reset: synchronous, active high; parser returns to hunting, totals clear, halt clears
// after an error result the block takes items but gives no result until reset
module srecord_s2_to_binary_top #(
   parameter int ADDRESS_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // text_char[7:0]
   input  logic        req_tlast,  // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // data_byte[7:0], byte_offset[31:8], error_code[34:32], zero
   output logic [1:0]  rsp_tuser   // result_kind
);
   import sr2b_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   res_type    out_ff;
   res_type    res;
   logic       advance;
   logic       req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   sr2b_core #(
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .text_char   (in_char_ff),
      .end_of_input(in_last_ff),
      .res         (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = res.valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && res.valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {5'd0, out_ff.err, out_ff.offset, out_ff.data};

endmodule

@@ hw/rtl/sr2b_core.sv @@
module sr2b_core #(
   parameter int ADDRESS_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       text_char,
   input  logic             end_of_input,
   output sr2b_pkg::res_type res
);
   import sr2b_pkg::*;

   localparam int TotW = ADDRESS_BITS + 1;
   localparam int CmpW = (TotW > OFFSET_W) ? TotW : OFFSET_W;

   logic [2:0]          phase_ff, phase_in;
   logic [3:0]          high_ff, high_in;
   logic                pending_ff, pending_in;
   logic [7:0]          count_ff, count_in;
   logic [OFFSET_W-1:0] addr_ff, addr_in;
   logic [7:0]          left_ff, left_in;
   logic [7:0]          sum_ff, sum_in;
   logic [TotW-1:0]     total_ff, total_in;
   logic                halted_ff, halted_in;

   logic [4:0]          hex;
   logic [7:0]          b;
   logic [7:0]          left_dec;
   logic [7:0]          payload_len;
   logic [OFFSET_W-1:0] addr_shift;
   logic [TotW:0]       total_sum;

   assign hex         = hex_decode(text_char);
   assign b           = {high_ff, hex[3:0]};
   assign left_dec    = left_ff - 8'd1;
   assign payload_len = count_ff - 8'd4;
   assign addr_shift  = {addr_ff[OFFSET_W-9:0], b};
   assign total_sum   = {1'b0, total_ff} + (TotW+1)'(payload_len);

   always_comb begin
      phase_in   = phase_ff;
      high_in    = high_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      addr_in    = addr_ff;
      left_in    = left_ff;
      sum_in     = sum_ff;
      total_in   = total_ff;
      halted_in  = halted_ff;
      res        = '0;
      if (step && !halted_ff) begin
         if (end_of_input) begin
            res.valid = 1'b1;
            if (phase_ff == PH_HUNT) begin
               res.kind = K_END;
            end else begin
               res.kind  = K_ERROR;
               res.err   = E_TRUNCATED;
               halted_in = 1'b1;
            end
         end else if (phase_ff == PH_HUNT) begin
            if (text_char == CH_S) phase_in = PH_TYPE;
         end else if (phase_ff == PH_TYPE) begin
            if (text_char != CH_TWO) begin
               res.valid = 1'b1;
               res.kind  = K_ERROR;
               res.err   = E_TYPE;
               halted_in = 1'b1;
            end else begin
               pending_in = 1'b0;
               high_in    = 4'd0;
               phase_in   = PH_COUNT;
            end
         end else if (!hex[4]) begin
            res.valid = 1'b1;
            res.kind  = K_ERROR;
            res.err   = E_NONHEX;
            halted_in = 1'b1;
         end else if (!pending_ff) begin
            high_in    = hex[3:0];
            pending_in = 1'b1;
         end else begin
            pending_in = 1'b0;
            case (phase_ff)
               PH_COUNT: begin
                  count_in = b;
                  sum_in   = b;
                  if (b < 8'd4) begin
                     res.valid = 1'b1;
                     res.kind  = K_ERROR;
                     res.err   = E_SHORT;
                     halted_in = 1'b1;
                  end else begin
                     addr_in  = '0;
                     left_in  = 8'd3;
                     phase_in = PH_ADDR;
                  end
               end
               PH_ADDR: begin
                  addr_in = addr_shift;
                  sum_in  = sum_ff + b;
                  left_in = left_dec;
                  if (left_dec == 8'd0) begin
                     if (CmpW'(addr_shift) != CmpW'(total_ff)) begin
                        res.valid = 1'b1;
                        res.kind  = K_ERROR;
                        res.err   = E_GAP;
                        halted_in = 1'b1;
                     end else begin
                        left_in  = payload_len;
                        phase_in = (payload_len != 8'd0) ? PH_DATA : PH_CSUM;
                     end
                  end
               end
               PH_DATA: begin
                  sum_in     = sum_ff + b;
                  addr_in    = addr_ff + OFFSET_W'(1);
                  left_in    = left_dec;
                  if (left_dec == 8'd0) phase_in = PH_CSUM;
                  res.valid  = 1'b1;
                  res.kind   = K_DATA;
                  res.data   = b;
                  res.offset = addr_ff;
               end
               default: begin
                  res.valid = 1'b1;
                  if ((8'hFF - sum_ff) != b) begin
                     res.kind  = K_ERROR;
                     res.err   = E_CHECKSUM;
                     halted_in = 1'b1;
                  end else begin
                     total_in = total_sum[TotW] ? {TotW{1'b1}} : total_sum[TotW-1:0];
                     phase_in = PH_HUNT;
                     res.kind = K_ACCEPT;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         high_ff    <= '0;
         pending_ff <= 1'b0;
         count_ff   <= '0;
         addr_ff    <= '0;
         left_ff    <= '0;
         sum_ff     <= '0;
         total_ff   <= '0;
         halted_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         high_ff    <= high_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
         addr_ff    <= addr_in;
         left_ff    <= left_in;
         sum_ff     <= sum_in;
         total_ff   <= total_in;
         halted_ff  <= halted_in;
      end
   end

endmodule

@@ hw/rtl/sr2b_checker.sv @@
`include "srecord_s2_to_binary_top_assert.svh"

module sr2b_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import sr2b_pkg::*;

   `SR2B_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result item changed while stalled")
   `SR2B_ASSERT(a_err_code, rsp_tvalid |-> ((rsp_tuser == K_ERROR) == (rsp_tdata[34:32] != E_NONE)), "error code does not match result kind")
   `SR2B_ASSERT(a_halt, rsp_tvalid && rsp_tready && rsp_tuser == K_ERROR |=> !rsp_tvalid, "result item after an error")
   `SR2B_ASSERT(a_no_data, rsp_tvalid && rsp_tuser != K_DATA |-> rsp_tdata[31:0] == 32'd0, "data fields set on a non data item")
   `SR2B_ASSERT_ALWAYS(a_reset, !reset && $past(reset) |-> !rsp_tvalid, "result item straight after reset")

endmodule

bind srecord_s2_to_binary_top sr2b_checker u_sr2b_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
